[rtl/core/radtan_distort_with_jacobian_core_macros.svh]
// ----------------------------------------------------------------------------
// radtan_distort_with_jacobian_core_macros.svh
// assertion macros used by the checker of the distortion core
// ----------------------------------------------------------------------------
`ifndef RADTAN_DISTORT_WITH_JACOBIAN_CORE_MACROS_SVH
`define RADTAN_DISTORT_WITH_JACOBIAN_CORE_MACROS_SVH

// same-cycle implication
`define RDJ_ASSERT_NOW(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("rdj assertion failed");

// next-cycle implication
`define RDJ_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("rdj assertion failed");

`endif

[rtl/core/rdj_pkg.sv]
// ----------------------------------------------------------------------------
// rdj_pkg
// types, constants and fixed-point helpers of the radial-tangential
// distortion core
// ----------------------------------------------------------------------------
package rdj_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 28;
    localparam int PROD_W    = 2 * WORD_BITS;
    localparam int SUM_W     = WORD_BITS + 5;
    localparam int NPR       = 7;
    localparam int NSTG      = 11;

    localparam int APB_DW    = (WORD_BITS > 32) ? 64 : 32;
    localparam int ADDR_LSB  = (WORD_BITS > 32) ? 3 : 2;
    localparam int PADDR_W   = ADDR_LSB + 2;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [SUM_W-1:0]     SUM_MAX  = SUM_W'(WORD_MAX);
    localparam logic signed [SUM_W-1:0]     SUM_MIN  = SUM_W'(WORD_MIN);

    localparam bit ONE_OVF = (FRAC_BITS >= WORD_BITS - 1);
    localparam logic signed [WORD_BITS-1:0] WORD_ONE =
        ONE_OVF ? WORD_MAX : $signed(WORD_BITS'(1) << FRAC_BITS);

    localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [PROD_W-1:0] LIM_NEG  = PROD_W'(1) << (WORD_BITS - 1);
    localparam logic [PROD_W-1:0] LIM_POS  = LIM_NEG - PROD_W'(1);

    typedef enum logic [1:0] {
        REG_K1 = 2'd0,
        REG_K2 = 2'd1,
        REG_P1 = 2'd2,
        REG_P2 = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic                          ovf;
        logic signed [WORD_BITS-1:0]   v;
    } t_rnd;

    typedef struct packed {
        logic                          ovf;
        logic [NPR-1:0][PROD_W-1:0]    pr;
        logic signed [WORD_BITS-1:0]   x;
        logic signed [WORD_BITS-1:0]   y;
        logic signed [WORD_BITS-1:0]   mx2;
        logic signed [WORD_BITS-1:0]   my2;
        logic signed [WORD_BITS-1:0]   mxy;
        logic signed [WORD_BITS-1:0]   p1y;
        logic signed [WORD_BITS-1:0]   p2x;
        logic signed [WORD_BITS-1:0]   p1x;
        logic signed [WORD_BITS-1:0]   p2y;
        logic signed [WORD_BITS-1:0]   r2;
        logic signed [WORD_BITS-1:0]   k1mx2;
        logic signed [WORD_BITS-1:0]   k1my2;
        logic signed [WORD_BITS-1:0]   k1mxy;
        logic signed [WORD_BITS-1:0]   p1mxy;
        logic signed [WORD_BITS-1:0]   p2mxy;
        logic signed [WORD_BITS-1:0]   s2;
        logic signed [WORD_BITS-1:0]   t2;
        logic signed [WORD_BITS-1:0]   kr;
        logic signed [WORD_BITS-1:0]   k1r2;
        logic signed [WORD_BITS-1:0]   p2s2;
        logic signed [WORD_BITS-1:0]   p1t2;
        logic signed [WORD_BITS-1:0]   krr2;
        logic signed [WORD_BITS-1:0]   krmx2;
        logic signed [WORD_BITS-1:0]   krmy2;
        logic signed [WORD_BITS-1:0]   krmxy;
        logic signed [WORD_BITS-1:0]   rad;
        logic signed [WORD_BITS-1:0]   xrad;
        logic signed [WORD_BITS-1:0]   yrad;
        logic signed [WORD_BITS-1:0]   jxx;
        logic signed [WORD_BITS-1:0]   jxy;
        logic signed [WORD_BITS-1:0]   jyy;
        logic signed [WORD_BITS-1:0]   dx;
        logic signed [WORD_BITS-1:0]   dy;
    } t_pipe;

    // full-width signed product
    function automatic logic [PROD_W-1:0] fmul(input logic signed [WORD_BITS-1:0] a,
                                               input logic signed [WORD_BITS-1:0] b);
        logic signed [PROD_W-1:0] pa;
        logic signed [PROD_W-1:0] pb;
        pa = PROD_W'(a);
        pb = PROD_W'(b);
        return PROD_W'(pa * pb);
    endfunction

    // round magnitude to nearest, ties away from zero, then saturate
    function automatic t_rnd fround(input logic [PROD_W-1:0] p);
        logic              neg;
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] sh;
        logic [PROD_W-1:0] lim;
        t_rnd              r;
        neg   = p[PROD_W-1];
        mag   = neg ? (~p + PROD_W'(1)) : p;
        sh    = (mag + RND_HALF) >> FRAC_BITS;
        lim   = neg ? LIM_NEG : LIM_POS;
        r.ovf = (sh > lim);
        if (r.ovf) begin
            sh = lim;
        end
        r.v = neg ? $signed(WORD_BITS'(~sh + PROD_W'(1))) : $signed(WORD_BITS'(sh));
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] ext(input logic signed [WORD_BITS-1:0] v);
        return SUM_W'(v);
    endfunction

    function automatic t_rnd fsat(input logic signed [SUM_W-1:0] s);
        t_rnd r;
        if (s > SUM_MAX) begin
            r.ovf = 1'b1;
            r.v   = WORD_MAX;
        end else if (s < SUM_MIN) begin
            r.ovf = 1'b1;
            r.v   = WORD_MIN;
        end else begin
            r.ovf = 1'b0;
            r.v   = $signed(WORD_BITS'(s));
        end
        return r;
    endfunction

endpackage

[rtl/core/radtan_distort_with_jacobian_core.sv]
// ----------------------------------------------------------------------------
// radtan_distort_with_jacobian_core
// radial-tangential lens distortion of a normalized point with its jacobian
// ----------------------------------------------------------------------------
// usage:
//   input channel i_in_valid / o_in_ready carries one point (x, y) in signed
//   Q4.28; output channel o_out_valid / i_out_ready carries the distorted
//   point, jac_xx, jac_xy, jac_yy and an overflow flag set when any product
//   or sum was clamped to the word range.
//   coefficients k1, k2, p1, p2 sit behind the apb port at byte offsets
//   0x0, 0x4, 0x8, 0xc; write them only while no transfer is in flight.
//   one point is taken every cycle unless the output stage is stalled,
//   through the eleven-stage multiply / round / add chain,
//   with one 32x32 multiplier per product and stage.
//   reset clears the coefficients to zero and empties the pipeline.
//   when the receiver stalls, the whole pipeline holds and o_in_ready drops
//   only while the output stage is full and not taken; nothing is lost.
// ----------------------------------------------------------------------------
module radtan_distort_with_jacobian_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rdj_pkg::PADDR_W-1:0]         paddr,
    input  logic [rdj_pkg::APB_DW-1:0]          pwdata,
    output logic [rdj_pkg::APB_DW-1:0]          prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [rdj_pkg::WORD_BITS-1:0] i_point_x,
    input  logic signed [rdj_pkg::WORD_BITS-1:0] i_point_y,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [rdj_pkg::WORD_BITS-1:0] o_distorted_x,
    output logic signed [rdj_pkg::WORD_BITS-1:0] o_distorted_y,
    output logic signed [rdj_pkg::WORD_BITS-1:0] o_jac_xx,
    output logic signed [rdj_pkg::WORD_BITS-1:0] o_jac_xy,
    output logic signed [rdj_pkg::WORD_BITS-1:0] o_jac_yy,
    output logic                                o_overflow
);

    localparam int W  = rdj_pkg::WORD_BITS;
    localparam int NS = rdj_pkg::NSTG;

    logic signed [W-1:0]   r_k1;
    logic signed [W-1:0]   r_k2;
    logic signed [W-1:0]   r_p1;
    logic signed [W-1:0]   r_p2;
    rdj_pkg::t_reg_idx     reg_idx;
    logic                  cfg_wr;

    logic [NS-1:0]         r_vld;
    logic [NS-1:0]         n_vld;
    rdj_pkg::t_pipe        r_st [NS];
    rdj_pkg::t_pipe        n_st [NS];
    logic                  adv;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = rdj_pkg::t_reg_idx'(paddr[rdj_pkg::ADDR_LSB +: 2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1 <= '0;
            r_k2 <= '0;
            r_p1 <= '0;
            r_p2 <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                rdj_pkg::REG_K1: r_k1 <= $signed(pwdata[W-1:0]);
                rdj_pkg::REG_K2: r_k2 <= $signed(pwdata[W-1:0]);
                rdj_pkg::REG_P1: r_p1 <= $signed(pwdata[W-1:0]);
                rdj_pkg::REG_P2: r_p2 <= $signed(pwdata[W-1:0]);
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rdj_pkg::REG_K1: prdata = rdj_pkg::APB_DW'(unsigned'(r_k1));
            rdj_pkg::REG_K2: prdata = rdj_pkg::APB_DW'(unsigned'(r_k2));
            rdj_pkg::REG_P1: prdata = rdj_pkg::APB_DW'(unsigned'(r_p1));
            rdj_pkg::REG_P2: prdata = rdj_pkg::APB_DW'(unsigned'(r_p2));
        endcase
    end

    // pipeline control
    assign adv        = !r_vld[NS-1] || i_out_ready;
    assign o_in_ready = adv;
    assign n_vld      = {r_vld[NS-2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_st <= n_st;
        end
    end

    // datapath stages
    always_comb begin
        rdj_pkg::t_rnd           rw [rdj_pkg::NPR];
        rdj_pkg::t_rnd           sa;
        rdj_pkg::t_rnd           sb;
        rdj_pkg::t_rnd           sc;
        logic                    rov;

        // stage 0: first products
        n_st[0]       = '0;
        n_st[0].x     = i_point_x;
        n_st[0].y     = i_point_y;
        n_st[0].pr[0] = rdj_pkg::fmul(i_point_x, i_point_x);
        n_st[0].pr[1] = rdj_pkg::fmul(i_point_y, i_point_y);
        n_st[0].pr[2] = rdj_pkg::fmul(i_point_x, i_point_y);
        n_st[0].pr[3] = rdj_pkg::fmul(r_p1, i_point_y);
        n_st[0].pr[4] = rdj_pkg::fmul(r_p2, i_point_x);
        n_st[0].pr[5] = rdj_pkg::fmul(r_p1, i_point_x);
        n_st[0].pr[6] = rdj_pkg::fmul(r_p2, i_point_y);

        // stage 1: round
        n_st[1] = r_st[0];
        rov = 1'b0;
        for (int i = 0; i < rdj_pkg::NPR; i++) begin
            rw[i] = rdj_pkg::fround(r_st[0].pr[i]);
            rov   = rov | rw[i].ovf;
        end
        n_st[1].mx2 = rw[0].v;
        n_st[1].my2 = rw[1].v;
        n_st[1].mxy = rw[2].v;
        n_st[1].p1y = rw[3].v;
        n_st[1].p2x = rw[4].v;
        n_st[1].p1x = rw[5].v;
        n_st[1].p2y = rw[6].v;
        n_st[1].ovf = r_st[0].ovf | rov;

        // stage 2: r2 and coefficient products
        n_st[2]       = r_st[1];
        sa            = rdj_pkg::fsat(rdj_pkg::ext(r_st[1].mx2) + rdj_pkg::ext(r_st[1].my2));
        n_st[2].r2    = sa.v;
        n_st[2].pr    = '0;
        n_st[2].pr[0] = rdj_pkg::fmul(r_k1, r_st[1].mx2);
        n_st[2].pr[1] = rdj_pkg::fmul(r_k1, r_st[1].my2);
        n_st[2].pr[2] = rdj_pkg::fmul(r_k1, r_st[1].mxy);
        n_st[2].pr[3] = rdj_pkg::fmul(r_p1, r_st[1].mxy);
        n_st[2].pr[4] = rdj_pkg::fmul(r_p2, r_st[1].mxy);
        n_st[2].ovf   = r_st[1].ovf | sa.ovf;

        // stage 3: round, tangential radii, r2 products
        n_st[3] = r_st[2];
        rov = 1'b0;
        for (int i = 0; i < rdj_pkg::NPR; i++) begin
            rw[i] = rdj_pkg::fround(r_st[2].pr[i]);
            rov   = rov | rw[i].ovf;
        end
        n_st[3].k1mx2 = rw[0].v;
        n_st[3].k1my2 = rw[1].v;
        n_st[3].k1mxy = rw[2].v;
        n_st[3].p1mxy = rw[3].v;
        n_st[3].p2mxy = rw[4].v;
        sa = rdj_pkg::fsat(rdj_pkg::ext(r_st[2].r2) + (rdj_pkg::ext(r_st[2].mx2) <<< 1));
        sb = rdj_pkg::fsat(rdj_pkg::ext(r_st[2].r2) + (rdj_pkg::ext(r_st[2].my2) <<< 1));
        n_st[3].s2    = sa.v;
        n_st[3].t2    = sb.v;
        n_st[3].pr    = '0;
        n_st[3].pr[0] = rdj_pkg::fmul(r_k2, r_st[2].r2);
        n_st[3].pr[1] = rdj_pkg::fmul(r_k1, r_st[2].r2);
        n_st[3].ovf   = r_st[2].ovf | rov | sa.ovf | sb.ovf;

        // stage 4: round, tangential products
        n_st[4] = r_st[3];
        rov = 1'b0;
        for (int i = 0; i < rdj_pkg::NPR; i++) begin
            rw[i] = rdj_pkg::fround(r_st[3].pr[i]);
            rov   = rov | rw[i].ovf;
        end
        n_st[4].kr    = rw[0].v;
        n_st[4].k1r2  = rw[1].v;
        n_st[4].pr    = '0;
        n_st[4].pr[0] = rdj_pkg::fmul(r_p2, r_st[3].s2);
        n_st[4].pr[1] = rdj_pkg::fmul(r_p1, r_st[3].t2);
        n_st[4].ovf   = r_st[3].ovf | rov;

        // stage 5: round, kr products
        n_st[5] = r_st[4];
        rov = 1'b0;
        for (int i = 0; i < rdj_pkg::NPR; i++) begin
            rw[i] = rdj_pkg::fround(r_st[4].pr[i]);
            rov   = rov | rw[i].ovf;
        end
        n_st[5].p2s2  = rw[0].v;
        n_st[5].p1t2  = rw[1].v;
        n_st[5].pr    = '0;
        n_st[5].pr[0] = rdj_pkg::fmul(r_st[4].kr, r_st[4].r2);
        n_st[5].pr[1] = rdj_pkg::fmul(r_st[4].kr, r_st[4].mx2);
        n_st[5].pr[2] = rdj_pkg::fmul(r_st[4].kr, r_st[4].my2);
        n_st[5].pr[3] = rdj_pkg::fmul(r_st[4].kr, r_st[4].mxy);
        n_st[5].ovf   = r_st[4].ovf | rov;

        // stage 6: round
        n_st[6] = r_st[5];
        rov = 1'b0;
        for (int i = 0; i < rdj_pkg::NPR; i++) begin
            rw[i] = rdj_pkg::fround(r_st[5].pr[i]);
            rov   = rov | rw[i].ovf;
        end
        n_st[6].krr2  = rw[0].v;
        n_st[6].krmx2 = rw[1].v;
        n_st[6].krmy2 = rw[2].v;
        n_st[6].krmxy = rw[3].v;
        n_st[6].ovf   = r_st[5].ovf | rov;

        // stage 7: radial factor
        n_st[7]     = r_st[6];
        sa          = rdj_pkg::fsat(rdj_pkg::ext(r_st[6].k1r2) + rdj_pkg::ext(r_st[6].krr2));
        n_st[7].rad = sa.v;
        n_st[7].ovf = r_st[6].ovf | sa.ovf;

        // stage 8: jacobian sums, point times radial factor
        n_st[8] = r_st[7];
        sa = rdj_pkg::fsat(rdj_pkg::ext(rdj_pkg::WORD_ONE) + rdj_pkg::ext(r_st[7].rad)
                           + (rdj_pkg::ext(r_st[7].k1mx2) <<< 1)
                           + (rdj_pkg::ext(r_st[7].krmx2) <<< 2)
                           + (rdj_pkg::ext(r_st[7].p1y) <<< 1)
                           + (rdj_pkg::ext(r_st[7].p2x) <<< 2)
                           + (rdj_pkg::ext(r_st[7].p2x) <<< 1));
        sb = rdj_pkg::fsat((rdj_pkg::ext(r_st[7].k1mxy) <<< 1)
                           + (rdj_pkg::ext(r_st[7].krmxy) <<< 2)
                           + (rdj_pkg::ext(r_st[7].p1x) <<< 1)
                           + (rdj_pkg::ext(r_st[7].p2y) <<< 1));
        sc = rdj_pkg::fsat(rdj_pkg::ext(rdj_pkg::WORD_ONE) + rdj_pkg::ext(r_st[7].rad)
                           + (rdj_pkg::ext(r_st[7].k1my2) <<< 1)
                           + (rdj_pkg::ext(r_st[7].krmy2) <<< 2)
                           + (rdj_pkg::ext(r_st[7].p2x) <<< 1)
                           + (rdj_pkg::ext(r_st[7].p1y) <<< 2)
                           + (rdj_pkg::ext(r_st[7].p1y) <<< 1));
        n_st[8].jxx   = sa.v;
        n_st[8].jxy   = sb.v;
        n_st[8].jyy   = sc.v;
        n_st[8].pr    = '0;
        n_st[8].pr[0] = rdj_pkg::fmul(r_st[7].x, r_st[7].rad);
        n_st[8].pr[1] = rdj_pkg::fmul(r_st[7].y, r_st[7].rad);
        n_st[8].ovf   = r_st[7].ovf | sa.ovf | sb.ovf | sc.ovf | rdj_pkg::ONE_OVF;

        // stage 9: round
        n_st[9] = r_st[8];
        rov = 1'b0;
        for (int i = 0; i < rdj_pkg::NPR; i++) begin
            rw[i] = rdj_pkg::fround(r_st[8].pr[i]);
            rov   = rov | rw[i].ovf;
        end
        n_st[9].xrad = rw[0].v;
        n_st[9].yrad = rw[1].v;
        n_st[9].ovf  = r_st[8].ovf | rov;

        // stage 10: distorted point, output register
        n_st[10] = r_st[9];
        sa = rdj_pkg::fsat(rdj_pkg::ext(r_st[9].x) + rdj_pkg::ext(r_st[9].xrad)
                           + (rdj_pkg::ext(r_st[9].p1mxy) <<< 1)
                           + rdj_pkg::ext(r_st[9].p2s2));
        sb = rdj_pkg::fsat(rdj_pkg::ext(r_st[9].y) + rdj_pkg::ext(r_st[9].yrad)
                           + (rdj_pkg::ext(r_st[9].p2mxy) <<< 1)
                           + rdj_pkg::ext(r_st[9].p1t2));
        n_st[10].dx  = sa.v;
        n_st[10].dy  = sb.v;
        n_st[10].ovf = r_st[9].ovf | sa.ovf | sb.ovf;
    end

    assign o_out_valid   = r_vld[NS-1];
    assign o_distorted_x = r_st[NS-1].dx;
    assign o_distorted_y = r_st[NS-1].dy;
    assign o_jac_xx      = r_st[NS-1].jxx;
    assign o_jac_xy      = r_st[NS-1].jxy;
    assign o_jac_yy      = r_st[NS-1].jyy;
    assign o_overflow    = r_st[NS-1].ovf;

endmodule

[rtl/core/rdj_core_chk.sv]
// ----------------------------------------------------------------------------
// rdj_core_chk
// port-level checks of the distortion core, bound to the core module
// ----------------------------------------------------------------------------
`include "radtan_distort_with_jacobian_core_macros.svh"

module rdj_core_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                pready,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [rdj_pkg::WORD_BITS-1:0] o_distorted_x,
    input logic signed [rdj_pkg::WORD_BITS-1:0] o_distorted_y,
    input logic signed [rdj_pkg::WORD_BITS-1:0] o_jac_xx,
    input logic signed [rdj_pkg::WORD_BITS-1:0] o_jac_xy,
    input logic signed [rdj_pkg::WORD_BITS-1:0] o_jac_yy,
    input logic                                o_overflow
);

    logic                              out_stall;
    logic [5*rdj_pkg::WORD_BITS:0]     out_bus;

    assign out_stall = o_out_valid && !i_out_ready;
    assign out_bus   = {o_distorted_x, o_distorted_y, o_jac_xx, o_jac_xy, o_jac_yy,
                        o_overflow};

    // stalled result holds
    `RDJ_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, out_stall, o_out_valid && $stable(out_bus))

    // pipeline empty after reset
    `RDJ_ASSERT_NEXT(a_rst_empty, i_clk, 1'b0, !i_rst_n, !o_out_valid)

    // input side only stalls behind a stalled output transfer
    `RDJ_ASSERT_NOW(a_ready_free, i_clk, !i_rst_n, !o_out_valid || i_out_ready, o_in_ready)

    // config port never waits
    `RDJ_ASSERT_NOW(a_pready, i_clk, !i_rst_n, 1'b1, pready)

endmodule

bind radtan_distort_with_jacobian_core rdj_core_chk u_rdj_core_chk (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the radial-tangential distortion core: points are
// streamed through the valid/ready input, each result is compared field by
// field with a fixed-point model of the distortion and its jacobian, under
// several coefficient settings written over apb and several idle patterns
// ----------------------------------------------------------------------------
module tb_top;

    localparam int W          = rdj_pkg::WORD_BITS;
    localparam int FB         = rdj_pkg::FRAC_BITS;
    localparam int SETTLE     = rdj_pkg::NSTG + 5;
    localparam int QUIET_MAX  = 3000;
    localparam int LONG_HOLD  = 400;
    localparam int PHASE_LEN  = 228;
    localparam longint WMAXL  = (longint'(1) << (W - 1)) - 1;
    localparam longint WMINL  = -(longint'(1) << (W - 1));

    typedef logic signed [W-1:0] t_word;

    typedef struct packed {
        t_word x;
        t_word y;
    } t_point;

    typedef struct packed {
        t_word dx;
        t_word dy;
        t_word jxx;
        t_word jxy;
        t_word jyy;
        logic  ovf;
    } t_distort;

    localparam t_word Q_ONE  = t_word'(longint'(1) << FB);
    localparam t_word Q_HALF = t_word'(longint'(1) << (FB - 1));
    localparam t_word Q_QTR  = t_word'(longint'(1) << (FB - 2));

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          psel       = 1'b0;
    logic                          penable    = 1'b0;
    logic                          pwrite     = 1'b0;
    logic [rdj_pkg::PADDR_W-1:0]   paddr      = '0;
    logic [rdj_pkg::APB_DW-1:0]    pwdata     = '0;
    logic [rdj_pkg::APB_DW-1:0]    prdata;
    logic                          pready;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    t_word                         i_point_x  = '0;
    t_word                         i_point_y  = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    t_word                         o_distorted_x;
    t_word                         o_distorted_y;
    t_word                         o_jac_xx;
    t_word                         o_jac_xy;
    t_word                         o_jac_yy;
    logic                          o_overflow;

    t_point   pending_points [$];
    t_distort expected_results [$];
    t_word    coef [4];

    int       send_idle_pct = 0;
    int       stall_pct     = 0;
    int       errors        = 0;
    int       points_sent   = 0;
    int       results_seen  = 0;
    int       ovf_seen      = 0;
    int       settings_used = 0;
    int       quiet_cycles  = 0;
    int       hold_left     = 0;
    bit       hold_request  = 1'b0;
    bit       hold_seen     = 1'b0;
    bit       sat_flag      = 1'b0;
    t_point   next_point;
    t_distort want;

    radtan_distort_with_jacobian_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_distorted_x (o_distorted_x),
        .o_distorted_y (o_distorted_y),
        .o_jac_xx      (o_jac_xx),
        .o_jac_xy      (o_jac_xy),
        .o_jac_yy      (o_jac_yy),
        .o_overflow    (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clamp_word(input longint v);
        if (v > WMAXL) begin
            sat_flag = 1'b1;
            return WMAXL;
        end
        if (v < WMINL) begin
            sat_flag = 1'b1;
            return WMINL;
        end
        return v;
    endfunction

    // exact product, magnitude rounded half away from zero, then clamped
    function automatic longint mul_round(input longint a, input longint b);
        bit              neg;
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned mag;
        longint unsigned lim;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        mag = (ua * ub + (64'd1 << (FB - 1))) >> FB;
        lim = neg ? -WMINL : WMAXL;
        if (mag > lim) begin
            sat_flag = 1'b1;
            mag      = lim;
        end
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic t_distort distort_point(input t_word px, input t_word py);
        longint   x, y, k1, k2, p1, p2;
        longint   one, mx2, my2, mxy, r2, kr, rad, s2, t2;
        longint   jxx, jxy, jyy, dx, dy;
        t_distort r;
        sat_flag = 1'b0;
        x   = px;
        y   = py;
        k1  = coef[rdj_pkg::REG_K1];
        k2  = coef[rdj_pkg::REG_K2];
        p1  = coef[rdj_pkg::REG_P1];
        p2  = coef[rdj_pkg::REG_P2];
        one = clamp_word(longint'(1) << FB);
        mx2 = mul_round(x, x);
        my2 = mul_round(y, y);
        mxy = mul_round(x, y);
        r2  = clamp_word(mx2 + my2);
        kr  = mul_round(k2, r2);
        rad = clamp_word(mul_round(k1, r2) + mul_round(kr, r2));
        jxx = clamp_word(one + rad + 2 * mul_round(k1, mx2)
                         + 4 * mul_round(kr, mx2) + 2 * mul_round(p1, y)
                         + 6 * mul_round(p2, x));
        jxy = clamp_word(2 * mul_round(k1, mxy) + 4 * mul_round(kr, mxy)
                         + 2 * mul_round(p1, x) + 2 * mul_round(p2, y));
        jyy = clamp_word(one + rad + 2 * mul_round(k1, my2)
                         + 4 * mul_round(kr, my2) + 2 * mul_round(p2, x)
                         + 6 * mul_round(p1, y));
        s2  = clamp_word(r2 + 2 * mx2);
        t2  = clamp_word(r2 + 2 * my2);
        dx  = clamp_word(x + mul_round(x, rad) + 2 * mul_round(p1, mxy)
                         + mul_round(p2, s2));
        dy  = clamp_word(y + mul_round(y, rad) + 2 * mul_round(p2, mxy)
                         + mul_round(p1, t2));
        r.dx  = dx[W-1:0];
        r.dy  = dy[W-1:0];
        r.jxx = jxx[W-1:0];
        r.jxy = jxy[W-1:0];
        r.jyy = jyy[W-1:0];
        r.ovf = sat_flag;
        return r;
    endfunction

    task automatic report(input string what, input t_word got, input t_word exp_val);
        errors++;
        if (errors <= 40) begin
            $display("%0t mismatch %s: got %h expected %h", $time, what, got, exp_val);
        end
    endtask

    task automatic check_field(input string what, input t_word got, input t_word exp_val);
        if (got !== exp_val) begin
            report(what, got, exp_val);
        end
    endtask

    // input side: transfers are predicted as they happen
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_point_x  <= '0;
            i_point_y  <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(distort_point(i_point_x, i_point_y));
                points_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_point = pending_points.pop_front();
                    i_in_valid <= 1'b1;
                    i_point_x  <= next_point.x;
                    i_point_y  <= next_point.y;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report("result with nothing pending", o_distorted_x, '0);
                end else begin
                    want = expected_results.pop_front();
                    check_field("distorted_x", o_distorted_x, want.dx);
                    check_field("distorted_y", o_distorted_y, want.dy);
                    check_field("jac_xx", o_jac_xx, want.jxx);
                    check_field("jac_xy", o_jac_xy, want.jxy);
                    check_field("jac_yy", o_jac_yy, want.jyy);
                    check_field("overflow", t_word'(o_overflow), t_word'(want.ovf));
                    if (want.ovf) begin
                        ovf_seen++;
                    end
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_request != hold_seen) begin
            hold_seen <= hold_request;
            hold_left <= LONG_HOLD;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_MAX) begin
            $display("tb_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic apb_access(input rdj_pkg::t_reg_idx idx, input bit wr, input t_word val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= rdj_pkg::PADDR_W'(int'(idx) << rdj_pkg::ADDR_LSB);
        pwdata  <= rdj_pkg::APB_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        if (!wr) begin
            check_field("register read-back", t_word'(prdata), coef[idx]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_coefs(input t_word k1, input t_word k2, input t_word p1,
                             input t_word p2);
        coef[rdj_pkg::REG_K1] = k1;
        coef[rdj_pkg::REG_K2] = k2;
        coef[rdj_pkg::REG_P1] = p1;
        coef[rdj_pkg::REG_P2] = p2;
        for (int i = 0; i < 4; i++) begin
            apb_access(rdj_pkg::t_reg_idx'(i), 1'b1, coef[i]);
        end
        for (int i = 0; i < 4; i++) begin
            apb_access(rdj_pkg::t_reg_idx'(i), 1'b0, '0);
        end
        settings_used++;
    endtask

    // sampled away from the active edge so that queue updates have settled
    task automatic drain();
        while (pending_points.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic add_point(input t_word x, input t_word y);
        t_point p;
        p.x = x;
        p.y = y;
        pending_points.push_back(p);
    endtask

    function automatic t_word pick_extreme();
        case ($urandom_range(6))
            0: return rdj_pkg::WORD_MAX;
            1: return rdj_pkg::WORD_MIN;
            2: return '0;
            3: return Q_ONE;
            4: return -Q_ONE;
            5: return t_word'(1);
            default: return t_word'(-1);
        endcase
    endfunction

    function automatic t_word rand_span(input int unsigned span);
        return t_word'(longint'($urandom_range(2 * span)) - longint'(span));
    endfunction

    // mostly points inside the usual normalized field of view
    function automatic t_word rand_coord();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return rand_span(32'd402653184);
            6, 7:             return t_word'($urandom);
            8:                return pick_extreme();
            default:          return rand_span(32'd1073741824);
        endcase
    endfunction

    function automatic t_word rand_coef(input int style, input int unsigned span);
        case (style)
            0:       return rand_span(span);
            1:       return t_word'($urandom);
            default: return pick_extreme();
        endcase
    endfunction

    task automatic run_phase(input int idle, input int stall, input int style,
                             input bit squeeze);
        send_idle_pct = 0;
        stall_pct     = 0;
        set_coefs(rand_coef(style, 32'd134217728), rand_coef(style, 32'd53687091),
                  rand_coef(style, 32'd2684355), rand_coef(style, 32'd2684355));
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int i = 0; i < PHASE_LEN / 2; i++) begin
            add_point(rand_coord(), rand_coord());
        end
        if (squeeze) begin
            hold_request <= ~hold_request;
        end
        drain();
        for (int i = PHASE_LEN / 2; i < PHASE_LEN; i++) begin
            add_point(rand_coord(), rand_coord());
        end
        drain();
    endtask

    initial begin
        coef[rdj_pkg::REG_K1] = '0;
        coef[rdj_pkg::REG_K2] = '0;
        coef[rdj_pkg::REG_P1] = '0;
        coef[rdj_pkg::REG_P2] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset coefficients: identity mapping, squares saturate at the corners
        add_point('0, '0);
        add_point(rdj_pkg::WORD_MAX, rdj_pkg::WORD_MAX);
        add_point(rdj_pkg::WORD_MIN, rdj_pkg::WORD_MIN);
        add_point(Q_ONE, '0);
        add_point('0, -Q_ONE);
        drain();

        set_coefs(-t_word'(75161928), t_word'(18790482), t_word'(268435), -t_word'(134218));
        add_point('0, '0);
        add_point(Q_HALF, Q_QTR);
        add_point(-Q_HALF, Q_HALF + Q_QTR);
        add_point(Q_ONE, Q_ONE);
        add_point(-Q_ONE, -Q_ONE);
        add_point(rdj_pkg::WORD_MAX, rdj_pkg::WORD_MIN);
        add_point(rdj_pkg::WORD_MIN, rdj_pkg::WORD_MAX);
        add_point(t_word'(1), t_word'(-1));
        add_point(t_word'(32'h5555_5555), t_word'(32'hAAAA_AAAA));
        drain();

        set_coefs(rdj_pkg::WORD_MAX, rdj_pkg::WORD_MAX, rdj_pkg::WORD_MAX,
                  rdj_pkg::WORD_MAX);
        add_point(Q_ONE, Q_ONE);
        add_point(-Q_ONE, Q_QTR);
        add_point(t_word'(1), t_word'(1));
        drain();

        set_coefs(rdj_pkg::WORD_MIN, rdj_pkg::WORD_MIN, rdj_pkg::WORD_MIN,
                  rdj_pkg::WORD_MIN);
        add_point(Q_ONE, -Q_ONE);
        add_point(rdj_pkg::WORD_MIN, rdj_pkg::WORD_MIN);
        add_point(Q_QTR, -Q_QTR);
        drain();

        run_phase(0, 0, 0, 1'b1);
        run_phase(78, 0, 1, 1'b0);
        run_phase(0, 78, 0, 1'b0);
        run_phase(35, 35, 2, 1'b0);
        run_phase(0, 0, 1, 1'b1);
        run_phase(78, 0, 0, 1'b0);
        run_phase(0, 78, 2, 1'b0);
        run_phase(35, 35, 0, 1'b0);

        $display("covered %0d points under %0d coefficient settings", points_sent,
                 settings_used);
        $display("checked %0d results, %0d of them saturated", results_seen, ovf_seen);
        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/rdj_pkg.sv
rtl/core/radtan_distort_with_jacobian_core.sv
rtl/core/rdj_core_chk.sv
tb/tb_top.sv
